### rtl/rcg_pkg.sv
`default_nettype none

package rcg_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int MAX_FRAMES   = 4096;

  localparam int SAMPLE_W   = 24;
  localparam int TARGET_W   = 17;
  localparam int FRAMES_W   = 13;
  localparam int OSC_W      = 4;
  localparam int CHAN_W     = 3;
  localparam int COUNT_W    = 4;
  localparam int LEVEL_W    = 31;
  localparam int STEP_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  // Level is Q1.30 and never leaves [0, 1.0].
  localparam logic [LEVEL_W-1:0]  ONE_Q30    = LEVEL_W'(32'h4000_0000);
  localparam logic [TARGET_W-1:0] TARGET_ONE = TARGET_W'(65536);
  // 1.4 in Q1.16.
  localparam logic [16:0]         COMP_Q16   = 17'd91750;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE     = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_MONO_CHANNEL  = CFG_INDEX_W'(2);

  typedef struct packed {
    logic load;
    logic div_step_go;
    logic step_write;
    logic advance;
    logic comp_mul;
    logic div_gain_go;
    logic gain_level;
    logic gain_div;
    logic mul;
    logic out_write;
  } rcg_cmd_t;

  typedef struct packed {
    logic start;
    logic ch_zero;
    logic comp;
    logic div_done;
    logic out_free;
  } rcg_status_t;

endpackage

`default_nettype wire

### rtl/rcg_ifs.sv
`default_nettype none

interface rcg_sample_if import rcg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       buffer_start;
  logic [TARGET_W-1:0]        target_level;
  logic [FRAMES_W-1:0]        frame_count;
  logic [OSC_W-1:0]           osc_count;

  modport source (output valid, sample_in, buffer_start, target_level, frame_count,
                  osc_count, input ready);
  modport sink (input valid, sample_in, buffer_start, target_level, frame_count,
                osc_count, output ready);
endinterface

interface rcg_result_if import rcg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [CHAN_W-1:0]          channel_out;

  modport source (output valid, sample_out, channel_out, input ready);
  modport sink (input valid, sample_out, channel_out, output ready);
endinterface

interface rcg_cfg_if import rcg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/rcg_divider.sv
`default_nettype none

module rcg_divider import rcg_pkg::*; #(
  parameter int DIVIDEND_W = LEVEL_W,
  parameter int DIVISOR_W  = FRAMES_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] work;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of work while quotient bits shift in at the bottom.
  assign trial      = {rem, work[DIVIDEND_W-1]};
  assign trial_diff = trial - {1'b0, den};
  assign fits       = trial >= {1'b0, den};
  assign rem_next   = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  assign quotient   = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      work <= {work[DIVIDEND_W-2:0], fits};
      rem  <= rem_next;
    end
  end

endmodule

`default_nettype wire

### rtl/rcg_datapath.sv
`default_nettype none

module rcg_datapath import rcg_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rcg_cmd_t                   cmd,
  output rcg_status_t                     status,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire logic                       buffer_start,
  input  wire logic [TARGET_W-1:0]        target_level,
  input  wire logic [FRAMES_W-1:0]        frame_count,
  input  wire logic [OSC_W-1:0]           osc_count,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      sample_out,
  output logic [CHAN_W-1:0]               channel_out
);

  localparam int CPROD_W = LEVEL_W + 17;
  localparam int PROD_W  = SAMPLE_W + LEVEL_W;

  // Configuration registers.
  logic [COUNT_W-1:0] channel_count;
  logic               mono_mode;
  logic [CHAN_W-1:0]  mono_channel;

  // Ramp and frame state.
  logic [CHAN_W-1:0]        channel_index;
  logic [LEVEL_W-1:0]       level;
  logic signed [STEP_W-1:0] level_step;
  logic                     step_neg;

  // Request held while it is worked on.
  logic signed [SAMPLE_W-1:0] sample;
  logic                       start_r;
  logic [TARGET_W-1:0]        target_r;
  logic [FRAMES_W-1:0]        frames_r;
  logic [OSC_W-1:0]           osc_r;
  logic [CHAN_W-1:0]          ch;
  logic                       gain_on;

  logic [CPROD_W-1:0] comp_prod;
  logic [LEVEL_W-1:0] gain;
  logic [PROD_W-1:0]  prod;

  logic [COUNT_W-1:0]       count_eff;
  logic [CHAN_W-1:0]        idx_in;
  logic [COUNT_W-1:0]       idx_inc;
  logic [CHAN_W-1:0]        channel_index_next;
  logic [TARGET_W-1:0]      target_c;
  logic [FRAMES_W-1:0]      frames_eff;
  logic signed [STEP_W-1:0] diff;
  logic [STEP_W-1:0]        diff_abs;
  logic signed [STEP_W:0]   level_sum;
  logic [LEVEL_W-1:0]       level_next;
  logic [CPROD_W-1:0]       comp_sum;
  logic [LEVEL_W-1:0]       comp_dividend;
  logic                     div_start;
  logic [LEVEL_W-1:0]       div_dividend;
  logic [FRAMES_W-1:0]      div_divisor;
  logic                     div_done;
  logic [LEVEL_W-1:0]       div_quotient;
  logic [STEP_W-1:0]        quot_ext;
  logic [SAMPLE_W-1:0]      sample_mag;
  logic [PROD_W:0]          rounded;
  logic [PROD_W-30:0]       res;
  logic signed [SAMPLE_W-1:0] scaled;

  always_comb begin
    if (channel_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (channel_count > COUNT_W'(MAX_CHANNELS)) begin
      count_eff = COUNT_W'(MAX_CHANNELS);
    end else begin
      count_eff = channel_count;
    end
  end

  // A buffer start, or a count lowered in mid-frame, makes this request channel 0.
  assign idx_in = (buffer_start || ({1'b0, channel_index} >= count_eff)) ? '0 : channel_index;
  assign idx_inc = {1'b0, idx_in} + COUNT_W'(1);
  assign channel_index_next = (idx_inc >= count_eff) ? '0 : idx_inc[CHAN_W-1:0];

  assign target_c = (target_r > TARGET_ONE) ? TARGET_ONE : target_r;

  always_comb begin
    if (frames_r == '0) begin
      frames_eff = FRAMES_W'(1);
    end else if (frames_r > FRAMES_W'(MAX_FRAMES)) begin
      frames_eff = FRAMES_W'(MAX_FRAMES);
    end else begin
      frames_eff = frames_r;
    end
  end

  assign diff     = $signed({1'b0, target_c, 14'b0}) - $signed({1'b0, level});
  assign diff_abs = diff[STEP_W-1] ? (~diff + 1'b1) : diff;

  assign level_sum = $signed({2'b0, level}) + $signed({level_step[STEP_W-1], level_step});

  always_comb begin
    if (level_sum < 0) begin
      level_next = '0;
    end else if (level_sum > $signed({2'b0, ONE_Q30})) begin
      level_next = ONE_Q30;
    end else begin
      level_next = level_sum[LEVEL_W-1:0];
    end
  end

  // (level * 1.4 + osc/2) / osc in Q1.30, rounded half up; the divide by
  // 65536 is taken first, which gives the same floor.
  assign comp_sum      = comp_prod + {{(CPROD_W - OSC_W - 15){1'b0}}, osc_r, 15'b0};
  assign comp_dividend = comp_sum[LEVEL_W+15:16];

  assign div_start    = cmd.div_step_go || cmd.div_gain_go;
  assign div_dividend = cmd.div_step_go ? diff_abs[LEVEL_W-1:0] : comp_dividend;
  assign div_divisor  = cmd.div_step_go ? frames_eff : {{(FRAMES_W - OSC_W){1'b0}}, osc_r};

  rcg_divider #(
    .DIVIDEND_W (LEVEL_W),
    .DIVISOR_W  (FRAMES_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign quot_ext = {1'b0, div_quotient};

  assign sample_mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

  assign rounded = {1'b0, prod} + ((PROD_W+1)'(1) << 29);
  assign res     = rounded[PROD_W:30];

  always_comb begin
    if (sample[SAMPLE_W-1]) begin
      if (res > (PROD_W-29)'(24'h80_0000)) begin
        scaled = $signed(24'h80_0000);
      end else begin
        scaled = $signed(~res[SAMPLE_W-1:0] + 1'b1);
      end
    end else begin
      if (res > (PROD_W-29)'(24'h7F_FFFF)) begin
        scaled = $signed(24'h7F_FFFF);
      end else begin
        scaled = $signed(res[SAMPLE_W-1:0]);
      end
    end
  end

  assign status.start    = start_r;
  assign status.ch_zero  = (ch == '0);
  assign status.comp     = gain_on && (osc_r != '0);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= COUNT_W'(2);
      mono_mode     <= 1'b0;
      mono_channel  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[COUNT_W-1:0];
        REG_MONO_MODE:     mono_mode     <= cfg_data[0];
        REG_MONO_CHANNEL:  mono_channel  <= cfg_data[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      level         <= '0;
      level_step    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        channel_index <= channel_index_next;
      end
      if (cmd.step_write) begin
        level_step <= step_neg ? $signed(~quot_ext + 1'b1) : $signed(quot_ext);
      end
      if (cmd.advance) begin
        level <= level_next;
      end
      if (cmd.out_write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample   <= sample_in;
      start_r  <= buffer_start;
      target_r <= target_level;
      frames_r <= frame_count;
      osc_r    <= osc_count;
      ch       <= idx_in;
      gain_on  <= !mono_mode || (idx_in == mono_channel);
    end
    if (cmd.div_step_go) begin
      step_neg <= diff[STEP_W-1];
    end
    if (cmd.comp_mul) begin
      comp_prod <= {17'b0, level} * {{LEVEL_W{1'b0}}, COMP_Q16};
    end
    if (cmd.gain_level) begin
      gain <= level;
    end else if (cmd.gain_div) begin
      gain <= div_quotient;
    end
    if (cmd.mul) begin
      prod <= {{LEVEL_W{1'b0}}, sample_mag} * {{SAMPLE_W{1'b0}}, gain};
    end
    if (cmd.out_write) begin
      sample_out  <= gain_on ? scaled : sample;
      channel_out <= ch;
    end
  end

endmodule

`default_nettype wire

### rtl/rcg_controller.sv
`default_nettype none

module rcg_controller import rcg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rcg_status_t status,
  output rcg_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAMP,
    S_STEP_WAIT,
    S_ADVANCE,
    S_GAIN,
    S_COMP_GO,
    S_COMP_WAIT,
    S_MUL,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RAMP;
        end
      end
      S_RAMP: begin
        if (status.start) begin
          cmd.div_step_go = 1'b1;
          state_next      = S_STEP_WAIT;
        end else begin
          state_next = S_ADVANCE;
        end
      end
      S_STEP_WAIT: begin
        if (status.div_done) begin
          cmd.step_write = 1'b1;
          state_next     = S_ADVANCE;
        end
      end
      S_ADVANCE: begin
        cmd.advance = status.ch_zero;
        state_next  = S_GAIN;
      end
      S_GAIN: begin
        if (status.comp) begin
          cmd.comp_mul = 1'b1;
          state_next   = S_COMP_GO;
        end else begin
          cmd.gain_level = 1'b1;
          state_next     = S_MUL;
        end
      end
      S_COMP_GO: begin
        cmd.div_gain_go = 1'b1;
        state_next      = S_COMP_WAIT;
      end
      S_COMP_WAIT: begin
        if (status.div_done) begin
          cmd.gain_div = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_write = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/ramped_channel_gain.sv
`default_nettype none

// Ramped channel gain: scales interleaved 24-bit audio samples, one channel per
// request, by a gain level that ramps linearly toward a target over a buffer.
// A request with buffer_start set begins a frame at channel 0 and loads a new
// ramp from target_level (Q1.16, clamped to 1.0) and frame_count; the level
// steps once at each frame start and stays within 0 to 1.0. A nonzero
// osc_count scales the gain by 1.4/osc_count. In mono mode only mono_channel
// is scaled and other channels pass through. Each request yields one result.
// A buffer start and a nonzero osc_count on a scaled channel each add a pass
// through the shared 31-step restoring divider that forms the ramp step and
// the compensated gain. The result sits in an output register, so the next
// request is taken while it waits. Configuration writes are always accepted
// and take effect at once.

module ramped_channel_gain import rcg_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  rcg_sample_if.sink   samples,
  rcg_result_if.source results,
  rcg_cfg_if.sink      cfg
);

  rcg_cmd_t    cmd;
  rcg_status_t status;
  logic        ready;

  assign samples.ready = ready;
  assign cfg.ready     = 1'b1;

  rcg_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  rcg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .sample_in    (samples.sample_in),
    .buffer_start (samples.buffer_start),
    .target_level (samples.target_level),
    .frame_count  (samples.frame_count),
    .osc_count    (samples.osc_count),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .sample_out   (results.sample_out),
    .channel_out  (results.channel_out)
  );

endmodule

`default_nettype wire
